// ===== hw/rtl/lgca_pkg.sv =====
// Package for the lease-gated command arbiter: codes, state enum and slot record type.
// No dependencies.
`timescale 1ns / 1ps
package lgca_pkg;
	localparam int NUM_CHANNELS = 6;

	localparam logic [2:0] FUNC_EVAL    = 3'd0;
	localparam logic [2:0] FUNC_ACQUIRE = 3'd1;
	localparam logic [2:0] FUNC_RELEASE = 3'd2;
	localparam logic [2:0] FUNC_CANCEL  = 3'd3;
	localparam logic [2:0] FUNC_DRAIN   = 3'd4;

	localparam logic [1:0] SRC_USER = 2'd0;
	localparam logic [1:0] SRC_IPC  = 2'd1;

	localparam logic [1:0] KIND_DECISION = 2'd0;
	localparam logic [1:0] KIND_DRAINED  = 2'd1;
	localparam logic [1:0] KIND_ACK      = 2'd2;
	localparam logic [1:0] KIND_EMPTY    = 2'd3;

	localparam logic [1:0] DISP_APPLIED   = 2'd0;
	localparam logic [1:0] DISP_DEFERRED  = 2'd1;
	localparam logic [1:0] DISP_COALESCED = 2'd2;
	localparam logic [1:0] DISP_REJECTED  = 2'd3;

	localparam logic [1:0] RSN_NONE      = 2'd0;
	localparam logic [1:0] RSN_INVALID   = 2'd1;
	localparam logic [1:0] RSN_NOCOAL    = 2'd2;
	localparam logic [1:0] RSN_LEASE     = 2'd3;

	localparam logic [1:0] CFG_DURATION = 2'd0;
	localparam logic [1:0] CFG_REPLACE  = 2'd1;

	localparam logic [15:0] MERGE_MAX = 16'hFFFF;

	typedef struct packed {
		logic [31:0] sequence_v;
		logic [31:0] fp;
		logic [47:0] tstamp;
		logic [15:0] merges;
	} slot_rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DRAIN_RD,
		ST_DRAIN_OUT
	} state_t;
endpackage

// ===== hw/rtl/lgca_slot_ram.sv =====
// Slot record memory: one write port, one registered read port.
// Depends on lgca_pkg for the slot record type.
`timescale 1ns / 1ps
module lgca_slot_ram
	import lgca_pkg::*;
#(
	parameter int DEPTH = 6,
	parameter int AW = 3
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  slot_rec_t       wdata,
	input  logic [AW-1:0]   raddr,
	output slot_rec_t       rdata
);
	slot_rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/lease_gated_command_arbiter.sv =====
// Top level of the lease-gated command arbiter: lease state, control sequencer, result port.
// Depends on lgca_pkg and lgca_slot_ram.
//
// channel  signals                               handshake
// command  start, busy, func .. fingerprint      accepted when start && !busy
// config   cfg_valid, cfg_ready, cfg_index/data  written when cfg_valid && cfg_ready
// result   res_valid, kind .. last               one cycle strobe, no backpressure
//
// An evaluate is accepted, which also launches the slot memory read, then decides and
// writes back in ST_EVAL. Lease ops take the same path through ST_EVAL. A drain
// alternates ST_DRAIN_RD and ST_DRAIN_OUT for each channel, walking the slot memory
// once per channel through its single read port.
// Reset clears the lease, counter and slot valid bits; slot records need no clearing.
`timescale 1ns / 1ps
module lease_gated_command_arbiter
	import lgca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [47:0] now_ms,
	input  logic [31:0] req_seq,
	input  logic [31:0] user_epoch,
	input  logic [2:0]  channel,
	input  logic [1:0]  source,
	input  logic        emergency,
	input  logic        allow_coalescing,
	input  logic [31:0] fingerprint,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        res_valid,
	output logic [1:0]  kind,
	output logic [1:0]  disposition,
	output logic [1:0]  reason_code,
	output logic        execute_now,
	output logic        held_by_lease,
	output logic [31:0] seq_value,
	output logic [2:0]  pending_count,
	output logic [2:0]  out_channel,
	output logic [31:0] out_fingerprint,
	output logic [47:0] parked_at_ms,
	output logic [15:0] merge_count,
	output logic        last
);
	localparam int AW = $clog2(NUM_CHANNELS);

	state_t state_q, state_d;
	logic [31:0] dur_q;
	logic        repl_q;
	logic        lease_q;
	logic [31:0] lepoch_q;
	logic [48:0] lend_q;
	logic [31:0] dcnt_q;
	logic [2:0]  inuse_q;
	logic [NUM_CHANNELS-1:0] valid_q;

	// Latched command.
	logic [2:0]  func_q;
	logic [47:0] now_q;
	logic [31:0] seq_q, epoch_q, fp_q;
	logic [2:0]  ch_q;
	logic [1:0]  src_q;
	logic        emer_q, allow_q;

	logic [2:0]  scan_q;
	logic [2:0]  ndrain_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	slot_rec_t       wdata, rdata;

	lgca_slot_ram #(.DEPTH(NUM_CHANNELS), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	wire accept = start && !busy;
	wire lch = (ch_q >= 3'd1) && (ch_q <= 3'd4) && ({1'b0, ch_q} < 4'(NUM_CHANNELS));
	wire [AW-1:0] ch_idx = ch_q[AW-1:0];
	wire expired = lease_q && ({1'b0, now_q} >= lend_q);
	wire lease_e = lease_q && !expired;
	wire [31:0] dcnt_n = dcnt_q + 32'd1;
	wire [48:0] new_end = {1'b0, now_q} + {17'd0, dur_q};
	wire slot_v = valid_q[ch_idx];
	wire [15:0] merge_n = (rdata.merges < MERGE_MAX) ? rdata.merges + 16'd1 : rdata.merges;

	// Remaining valid slots above the scan point decide the last mark.
	logic more;
	always_comb begin
		more = 1'b0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			if (3'(k) > scan_q && valid_q[k]) more = 1'b1;
		end
	end

	assign raddr = (state_q == ST_IDLE) ? channel[AW-1:0] : scan_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && func <= FUNC_DRAIN) begin
				state_d = (func == FUNC_DRAIN) ? ST_DRAIN_RD : ST_EVAL;
			end
			ST_EVAL: state_d = ST_IDLE;
			ST_DRAIN_RD: state_d = ST_DRAIN_OUT;
			ST_DRAIN_OUT: state_d = (scan_q == 3'(NUM_CHANNELS - 1)) ? ST_IDLE : ST_DRAIN_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// Result and write-back logic.
	always_comb begin
		res_valid = 1'b0;
		kind = KIND_DECISION; disposition = DISP_APPLIED; reason_code = RSN_NONE;
		execute_now = 1'b0; held_by_lease = 1'b0; seq_value = 32'd0;
		pending_count = inuse_q; out_channel = 3'd0; out_fingerprint = 32'd0;
		parked_at_ms = 48'd0; merge_count = 16'd0; last = 1'b1;
		we = 1'b0; waddr = ch_idx;
		wdata = '{sequence_v: seq_q, fp: fp_q, tstamp: now_q, merges: 16'd0};
		case (state_q)
			ST_EVAL: begin
				res_valid = 1'b1;
				case (func_q)
					FUNC_EVAL: begin
						if (seq_q == 32'd0) begin
							disposition = DISP_REJECTED; reason_code = RSN_INVALID;
							held_by_lease = lease_q; seq_value = dcnt_q;
						end else begin
							seq_value = dcnt_n;
							if (emer_q) begin
								execute_now = 1'b1; pending_count = 3'd0;
							end else if (src_q == SRC_USER && lch) begin
								execute_now = 1'b1;
							end else if (!(src_q == SRC_IPC && lch && lease_e)) begin
								execute_now = 1'b1;
							end else if (!allow_q) begin
								disposition = DISP_REJECTED; reason_code = RSN_NOCOAL;
								held_by_lease = 1'b1;
							end else if (!slot_v) begin
								disposition = DISP_DEFERRED; reason_code = RSN_LEASE;
								held_by_lease = 1'b1; we = 1'b1;
								pending_count = inuse_q + 3'd1;
							end else begin
								disposition = DISP_COALESCED; reason_code = RSN_LEASE;
								held_by_lease = 1'b1;
								if (repl_q || rdata.fp != fp_q) begin
									we = 1'b1; wdata.merges = merge_n;
								end
							end
						end
					end
					FUNC_RELEASE: begin
						kind = KIND_ACK;
						execute_now = lease_e && (epoch_q == 32'd0 || epoch_q == lepoch_q);
					end
					default: kind = KIND_ACK;
				endcase
			end
			ST_DRAIN_OUT: begin
				if (valid_q[scan_q[AW-1:0]]) begin
					res_valid = 1'b1; kind = KIND_DRAINED; pending_count = 3'd0;
					seq_value = rdata.sequence_v; out_channel = scan_q;
					out_fingerprint = rdata.fp; parked_at_ms = rdata.tstamp;
					merge_count = rdata.merges; last = !more;
				end else if (scan_q == 3'(NUM_CHANNELS - 1) && ndrain_q == 3'd0) begin
					res_valid = 1'b1; kind = KIND_EMPTY; pending_count = 3'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dur_q <= 32'd1000; repl_q <= 1'b0;
			lease_q <= 1'b0; lepoch_q <= 32'd0; lend_q <= 49'd0;
			dcnt_q <= 32'd0; inuse_q <= 3'd0; valid_q <= '0;
			scan_q <= 3'd0; ndrain_q <= 3'd0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				if (cfg_index == CFG_DURATION) dur_q <= cfg_data;
				else if (cfg_index == CFG_REPLACE) repl_q <= cfg_data[0];
			end
			if (accept) begin
				scan_q <= 3'd0; ndrain_q <= 3'd0;
			end
			case (state_q)
				ST_EVAL: begin
					case (func_q)
						FUNC_EVAL: if (seq_q != 32'd0) begin
							dcnt_q <= dcnt_n;
							if (emer_q) begin
								lease_q <= 1'b0; lend_q <= 49'd0;
								valid_q <= '0; inuse_q <= 3'd0;
							end else if (src_q == SRC_USER && lch) begin
								lease_q <= 1'b1; lend_q <= new_end;
								lepoch_q <= (epoch_q != 32'd0) ? epoch_q : seq_q;
							end else begin
								if (expired) begin lease_q <= 1'b0; lend_q <= 49'd0; end
								if (we && !slot_v) begin
									valid_q[ch_idx] <= 1'b1; inuse_q <= inuse_q + 3'd1;
								end
							end
						end
						FUNC_ACQUIRE: if (epoch_q != 32'd0) begin
							lease_q <= 1'b1; lepoch_q <= epoch_q; lend_q <= new_end;
						end
						FUNC_RELEASE: if (expired || execute_now) begin
							lease_q <= 1'b0; lend_q <= 49'd0;
						end
						default: begin
							lease_q <= 1'b0; lend_q <= 49'd0;
						end
					endcase
				end
				ST_DRAIN_RD: if (scan_q == 3'd0 && expired) begin
					lease_q <= 1'b0; lend_q <= 49'd0;
				end
				ST_DRAIN_OUT: begin
					if (valid_q[scan_q[AW-1:0]]) begin
						valid_q[scan_q[AW-1:0]] <= 1'b0;
						ndrain_q <= ndrain_q + 3'd1;
					end
					inuse_q <= 3'd0;
					scan_q <= scan_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func; now_q <= now_ms; seq_q <= req_seq;
			epoch_q <= user_epoch; ch_q <= channel; src_q <= source;
			emer_q <= emergency; allow_q <= allow_coalescing; fp_q <= fingerprint;
		end
	end
endmodule
